// ----- sv/positional_pid_integral_separation_top_assert.svh -----
// Assertion macros for the PID controller top level.
// Each expects clk and rst in scope; checks are off while rst is high.
`ifndef POSITIONAL_PID_INTEGRAL_SEPARATION_TOP_ASSERT_SVH
`define POSITIONAL_PID_INTEGRAL_SEPARATION_TOP_ASSERT_SVH

// Same-cycle implication.
`define PPIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PPIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ppis_pkg.sv -----
`timescale 1ns / 1ps
package ppis_pkg;

  localparam int IN_W    = 20;   // offset, target, measured, correction
  localparam int THR_W   = 12;
  localparam int GAIN_W  = 16;
  localparam int ZONE_W  = 21;
  localparam int LIM_W   = 31;
  localparam int ERR_W   = 22;
  localparam int DIFF_W  = 23;
  localparam int INT_W   = 32;
  localparam int ACC_W   = 33;   // integral plus error before clamp
  localparam int DRIVE_W = 32;

  localparam int PP_W    = GAIN_W + 1 + ERR_W;    // p product
  localparam int IP_W    = GAIN_W + 1 + INT_W;    // i product
  localparam int DP_W    = GAIN_W + 1 + DIFF_W;   // d product
  localparam int SUM_W   = 50;
  localparam int FRAC_W  = 8;
  localparam int RND_W   = SUM_W - FRAC_W;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_I_GAIN         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_D_GAIN         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_CORR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_ZONE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_FLOOR = 3'd7;

  typedef struct packed {
    logic [GAIN_W-1:0]        p_gain;
    logic [GAIN_W-1:0]        i_gain;
    logic [GAIN_W-1:0]        d_gain;
    logic signed [IN_W-1:0]   error_correction;
    logic [ZONE_W-1:0]        integral_zone;
    logic [LIM_W-1:0]         integral_limit;
    logic [LIM_W-1:0]         output_limit;
    logic [THR_W-1:0]         throttle_floor;
  } cfg_t;

  // One classified tick, handed from front to back.
  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
    logic signed [INT_W-1:0]  int_used;   // zero when outside the zone
  } q_entry_t;

  typedef struct packed {
    logic take;       // back pulls an entry this cycle
    logic s1_valid;
    logic s2_valid;
  } back_status_t;

endpackage

// ----- sv/ppis_if.sv -----
`timescale 1ns / 1ps
interface ppis_tick_if import ppis_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic signed [IN_W-1:0]  command_offset;
  logic signed [IN_W-1:0]  target;
  logic signed [IN_W-1:0]  measured;
  logic [THR_W-1:0]        throttle;

  modport source (output valid, command_offset, target, measured, throttle,
                  input ready);
  modport sink   (input valid, command_offset, target, measured, throttle,
                  output ready);
endinterface

interface ppis_result_if import ppis_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;
  logic                      saturated;

  modport source (output valid, drive, saturated, input ready);
  modport sink   (input valid, drive, saturated, output ready);
endinterface

interface ppis_cfg_if import ppis_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_W-1:0]    index;
  logic [CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/positional_pid_integral_separation_top.sv -----
`timescale 1ns / 1ps
// Positional PID controller with integral separation and integral reset on
// low throttle. Each tick transaction carries command_offset, target and
// measured (signed Q12.8) and a throttle reading; each one yields exactly one
// result transaction with drive (signed Q.8, saturated to +/- output_limit)
// and a saturated flag. The block takes one tick per clock cycle while its
// queue has room. A result reaches the result channel through the queue,
// stage 1, stage 2 and the output register. The front stage computes the
// error, its difference from the previous error and the clamped integral in
// the cycle of acceptance, since each tick needs the state the previous one
// left; it drops the classified tick into a four-entry queue. The back end is
// three registered stages: gain multiplies, sum with round half up to Q.8,
// then output saturation into the output register. A stalled result channel
// fills the back stages, then the queue, and only then drops tick ready.
// Registers are written through cfg (index 0..7: p, i, d gains, error
// correction, integral zone, integral limit, output limit, throttle floor);
// write them only while no tick is in flight. cfg is always ready.
module positional_pid_integral_separation_top import ppis_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  ppis_tick_if.sink      tick,
  ppis_result_if.source  result,
  ppis_cfg_if.sink       cfg
);

  cfg_t          regs;
  logic          push;
  q_entry_t      push_entry;
  logic          q_full;
  logic          q_not_empty;
  q_entry_t      q_head;
  logic [QCNT_W-1:0] q_level;
  back_status_t  bk;

  // ---- configuration registers ----
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_P_GAIN:         regs.p_gain           <= cfg.data[GAIN_W-1:0];
        REG_I_GAIN:         regs.i_gain           <= cfg.data[GAIN_W-1:0];
        REG_D_GAIN:         regs.d_gain           <= cfg.data[GAIN_W-1:0];
        REG_ERROR_CORR:     regs.error_correction <= $signed(cfg.data[IN_W-1:0]);
        REG_INTEGRAL_ZONE:  regs.integral_zone    <= cfg.data[ZONE_W-1:0];
        REG_INTEGRAL_LIMIT: regs.integral_limit   <= cfg.data[LIM_W-1:0];
        REG_OUTPUT_LIMIT:   regs.output_limit     <= cfg.data[LIM_W-1:0];
        REG_THROTTLE_FLOOR: regs.throttle_floor   <= cfg.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- front: error, derivative, integral state ----
  ppis_front u_front (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick),
    .cfg    (regs),
    .q_full (q_full),
    .push   (push),
    .entry  (push_entry)
  );

  // ---- decoupling queue ----
  ppis_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_entry  (push_entry),
    .pop       (bk.take),
    .not_empty (q_not_empty),
    .full      (q_full),
    .rd_entry  (q_head),
    .level     (q_level)
  );

  // ---- back: multiply, sum/round, saturate ----
  ppis_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (regs),
    .q_valid (q_not_empty),
    .q_entry (q_head),
    .status  (bk),
    .result  (result)
  );

  // ---- checks ----
  `include "positional_pid_integral_separation_top_assert.svh"

  // an accepted tick must land in the queue
  `PPIS_ASSERT_NEXT(a_push_lands, tick.valid && tick.ready, q_level != '0,
                    "accepted tick missing from queue")
  // tick ready drops only when the queue is full
  `PPIS_ASSERT_NOW(a_ready_full, !tick.ready, q_level == QCNT_W'(QDEPTH),
                   "tick stalled with room in queue")
  // an entry pulled by the back end occupies stage 1 next cycle
  `PPIS_ASSERT_NEXT(a_take_s1, bk.take, bk.s1_valid,
                    "queue entry lost entering back end")
  // the back end never pulls from an empty queue
  `PPIS_ASSERT_NOW(a_take_nonempty, bk.take, q_level != '0,
                   "back end pulled from empty queue")

endmodule

// ----- sv/ppis_front.sv -----
`timescale 1ns / 1ps
module ppis_front import ppis_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  ppis_tick_if.sink     tick,
  input  cfg_t          cfg,
  input  logic          q_full,
  output logic          push,
  output q_entry_t      entry
);

  logic signed [ERR_W-1:0]  prev_err;
  logic signed [INT_W-1:0]  integral;
  logic signed [INT_W-1:0]  integral_next;

  logic signed [ERR_W-1:0]  err;
  logic signed [DIFF_W-1:0] diff;
  logic [ERR_W-1:0]         mag;
  logic                     use_int;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  lim;

  assign tick.ready = !q_full;
  assign push       = tick.valid && tick.ready;

  // error cannot wrap: four 20-bit terms fit 22 bits
  assign err  = ERR_W'(tick.command_offset) + ERR_W'(tick.target)
              - ERR_W'(tick.measured) + ERR_W'(cfg.error_correction);
  assign diff = DIFF_W'(err) - DIFF_W'(prev_err);
  assign mag  = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
  assign use_int = mag < ERR_W'(cfg.integral_zone);

  assign acc = ACC_W'(integral) + ACC_W'(err);
  assign lim = ACC_W'($signed({1'b0, cfg.integral_limit}));

  always_comb begin
    if (acc > lim) begin
      integral_next = lim[INT_W-1:0];
    end else if (acc < -lim) begin
      integral_next = INT_W'(-lim);
    end else begin
      integral_next = acc[INT_W-1:0];
    end
    // low throttle wins over the clamp
    if (tick.throttle < cfg.throttle_floor) begin
      integral_next = '0;
    end
  end

  assign entry.err      = err;
  assign entry.diff     = diff;
  assign entry.int_used = use_int ? integral_next : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err <= '0;
      integral <= '0;
    end else if (push) begin
      prev_err <= err;
      integral <= integral_next;
    end
  end

endmodule

// ----- sv/ppis_queue.sv -----
`timescale 1ns / 1ps
module ppis_queue import ppis_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  q_entry_t          wr_entry,
  input  logic              pop,
  output logic              not_empty,
  output logic              full,
  output q_entry_t          rd_entry,
  output logic [QCNT_W-1:0] level
);

  q_entry_t            slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  logic do_push;
  logic do_pop;

  assign full      = count == QCNT_W'(QDEPTH);
  assign not_empty = count != '0;
  assign rd_entry  = slots[rd_ptr];
  assign level     = count;

  assign do_push = push && !full;
  assign do_pop  = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/ppis_back.sv -----
`timescale 1ns / 1ps
module ppis_back import ppis_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  cfg_t            cfg,
  input  logic            q_valid,
  input  q_entry_t        q_entry,
  output back_status_t    status,
  ppis_result_if.source   result
);

  // stage 1: products
  logic                     s1_valid;
  logic signed [PP_W-1:0]   p_prod;
  logic signed [IP_W-1:0]   i_prod;
  logic signed [DP_W-1:0]   d_prod;
  // stage 2: rounded sum
  logic                     s2_valid;
  logic signed [RND_W-1:0]  rnd;
  // output register
  logic                     out_valid;
  logic signed [DRIVE_W-1:0] drive;
  logic                     sat;

  logic out_ld, s2_ld, s1_ld, take;
  logic signed [SUM_W-1:0]  sum;
  logic signed [RND_W-1:0]  olim;

  assign out_ld = !out_valid || result.ready;
  assign s2_ld  = !s2_valid || out_ld;
  assign s1_ld  = !s1_valid || s2_ld;
  assign take   = q_valid && s1_ld;

  assign sum  = SUM_W'(p_prod) + SUM_W'(i_prod) + SUM_W'(d_prod)
              + SUM_W'(1 << (FRAC_W - 1));
  assign olim = RND_W'($signed({1'b0, cfg.output_limit}));

  always_ff @(posedge clk) begin
    if (s1_ld) begin
      p_prod <= PP_W'($signed({1'b0, cfg.p_gain})) * PP_W'(q_entry.err);
      i_prod <= IP_W'($signed({1'b0, cfg.i_gain})) * IP_W'(q_entry.int_used);
      d_prod <= DP_W'($signed({1'b0, cfg.d_gain})) * DP_W'(q_entry.diff);
    end
    if (s2_ld) begin
      rnd <= sum[SUM_W-1:FRAC_W];   // floor after half bias
    end
    if (out_ld) begin
      if (rnd > olim) begin
        drive <= olim[DRIVE_W-1:0];
        sat   <= 1'b1;
      end else if (rnd < -olim) begin
        drive <= DRIVE_W'(-olim);
        sat   <= 1'b1;
      end else begin
        drive <= rnd[DRIVE_W-1:0];
        sat   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ld) begin
        s1_valid <= take;
      end
      if (s2_ld) begin
        s2_valid <= s1_valid;
      end
      if (out_ld) begin
        out_valid <= s2_valid;
      end
    end
  end

  assign result.valid     = out_valid;
  assign result.drive     = drive;
  assign result.saturated = sat;

  assign status.take     = take;
  assign status.s1_valid = s1_valid;
  assign status.s2_valid = s2_valid;

endmodule
